### rtl/lmep_pkg.sv
// Shared types, constants and codes of the list-mode event parser.
package lmep_pkg;

    localparam int WORD_W     = 32;
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 14;
    localparam int ID_W       = 4;
    localparam int TIME_W     = 64;
    localparam int ENERGY_W   = 16;
    localparam int SAMPLES_W  = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // time divider: 16-bit digits over the 64-bit word
    localparam int DIGIT_W     = 16;
    localparam int DIGITS      = TIME_W / DIGIT_W;
    // input register, fraction stage, time-sum stage, then one stage per digit
    localparam int LMEP_NSTAGE = 3 + DIGITS;

    // reciprocals of 5: ceil(2^21/5) for the fraction, ceil(2^22/5) per digit
    localparam logic [18:0] RECIP_FRAC  = 19'd419431;
    localparam int          RECIP_FRAC_SH  = 21;
    localparam logic [19:0] RECIP_DIGIT = 20'd838861;
    localparam int          RECIP_DIGIT_SH = 22;

    // word positions of the fixed header
    localparam logic [INDEX_W-1:0] POS_HEADER  = 14'd0;
    localparam logic [INDEX_W-1:0] POS_TS_LOW  = 14'd1;
    localparam logic [INDEX_W-1:0] POS_TS_HIGH = 14'd2;
    localparam logic [INDEX_W-1:0] POS_ENERGY  = 14'd3;
    localparam logic [INDEX_W-1:0] FIXED_WORDS = 14'd4;
    localparam logic [INDEX_W-1:0] ESUM_WORDS  = 14'd4;

    // header lengths with known layouts
    localparam logic [4:0] HDR_ESUM = 5'd8;
    localparam logic [4:0] HDR_QDC  = 5'd12;
    localparam logic [4:0] HDR_BOTH = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_ESUM    = 2'd1,
        KIND_QDC     = 2'd2,
        KIND_TRACE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RATE_100  = 2'd0,
        RATE_250  = 2'd1,
        RATE_500  = 2'd2,
        RATE_NONE = 2'd3
    } t_rate;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE  = 1'd0,
        CFG_TRACE = 1'd1
    } t_cfg_reg;

    // one pipeline stage: result fields plus time work fields
    typedef struct packed {
        t_kind                kind;
        logic [INDEX_W-1:0]   index;
        logic [WORD_W-1:0]    value;
        logic [12:0]          ids;
        logic [ENERGY_W-1:0]  energy;
        logic [SAMPLES_W-1:0] samples;
        logic                 oor;
        logic                 forced;
        logic [47:0]          ts;
        logic [15:0]          cfd;
        t_rate                mode;
        logic signed [16:0]   frac;
        logic [TIME_W-1:0]    tval;
        logic [TIME_W-1:0]    quo;
        logic [2:0]           rem;
    } t_pipe;

endpackage

### rtl/lmep_if.sv
// Valid/ready channel interfaces for stream words and parsed items.
interface lmep_word_if;
    import lmep_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] stream_word;

    modport source (output valid, output stream_word, input ready);
    modport sink   (input valid, input stream_word, output ready);
endinterface

interface lmep_item_if;
    import lmep_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    item_kind;
    logic [INDEX_W-1:0]   item_index;
    logic [WORD_W-1:0]    item_value;
    logic [ID_W-1:0]      channel_id;
    logic [ID_W-1:0]      slot_id;
    logic [ID_W-1:0]      crate_id;
    logic                 finish_flag;
    logic [TIME_W-1:0]    event_time;
    logic                 cfd_forced;
    logic [ENERGY_W-1:0]  event_energy;
    logic [SAMPLES_W-1:0] trace_samples;
    logic                 out_of_range;

    modport source (
        output valid, input ready,
        output item_kind, output item_index, output item_value,
        output channel_id, output slot_id, output crate_id, output finish_flag,
        output event_time, output cfd_forced, output event_energy,
        output trace_samples, output out_of_range
    );
    modport sink (
        input valid, output ready,
        input item_kind, input item_index, input item_value,
        input channel_id, input slot_id, input crate_id, input finish_flag,
        input event_time, input cfd_forced, input event_energy,
        input trace_samples, input out_of_range
    );
endinterface

### rtl/list_mode_event_parser.sv
// List-mode event parser top level: header decode, item pipeline, time divider.
//
// Usage:
//   i_word carries one 32-bit stream word per handshake (valid & ready).
//   o_item carries one parsed item per handshake: an event summary on
//   header word 3, energy-sum and QDC words from the extended header, and
//   trace words when trace output is enabled. Words that make no item
//   (words 0..2, unknown header layouts, skipped traces) are consumed.
//   i_cfg_we/i_cfg_idx/i_cfg_data write rate mode (index 0) and trace
//   enable (index 1); write them only between events or while quiet.
// Throughput and pipeline:
//   one word per cycle while i_word.ready is high. An item leaves
//   through a seven-register pipeline (input, CFD fraction, time sum,
//   four 16-bit digits of the /5 used by the 250 MHz scaling).
// Stall:
//   each stage moves when the stage after it is empty or moving, so holes
//   close up under a stalled receiver; i_word.ready drops only when all
//   seven stages hold items.
// Reset:
//   synchronous, active low. Clears the word position, held header fields,
//   configuration and all stage valids; the first word after reset is
//   taken as header word 0.
module list_mode_event_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lmep_word_if.sink                           i_word,
    lmep_item_if.source                         o_item,
    input  logic                                i_cfg_we,
    input  logic [lmep_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lmep_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lmep_pkg::*;

    localparam int LAST = LMEP_NSTAGE - 1;

    // held event state
    logic [INDEX_W-1:0] r_pos, n_pos;
    logic [4:0]         r_hl, n_hl;
    logic [INDEX_W-1:0] r_el, n_el;
    logic [12:0]        r_ids, n_ids;
    logic [WORD_W-1:0]  r_tlo, n_tlo;
    logic [WORD_W-1:0]  r_thi, n_thi;

    // configuration
    t_rate r_mode;
    logic  r_trace;

    // pipeline
    t_pipe                  r_st [LMEP_NSTAGE];
    t_pipe                  n_st [LMEP_NSTAGE];
    t_pipe                  n_in;
    logic [LMEP_NSTAGE-1:0] r_v;
    logic [LMEP_NSTAGE:0]   rdy;

    logic in_acc;
    logic in_emit;

    // ---------------------------------------------------------------
    // stage functions
    // ---------------------------------------------------------------

    // CFD fraction and force flag per rate mode
    function automatic t_pipe f_frac(input t_pipe p);
        t_pipe              s;
        logic [15:0]        c;
        logic signed [16:0] v;
        logic [15:0]        a;
        logic [17:0]        pr;
        logic [36:0]        prod;
        logic [16:0]        qx;
        logic               frc;
        s    = p;
        c    = p.cfd;
        frc  = 1'b0;
        v    = $signed({1'b0, c[15:13], c[12:0]}) - 17'sd8192;
        a    = v[16] ? 16'(-v) : v[15:0];
        pr   = {a, 2'b00};
        prod = 37'(pr) * 37'(RECIP_FRAC);
        qx   = {1'b0, prod[RECIP_FRAC_SH +: 16]};
        case (p.mode)
            RATE_100: begin
                s.frac = $signed({2'b00, c[14:0]});
                frc    = c[15];
            end
            RATE_250: begin
                frc    = c[15];
                s.frac = c[15] ? 17'sd16384 : $signed({{3{c[14]}}, c[13:0]});
            end
            RATE_500: begin
                if (c[15:13] == 3'b111) begin
                    frc    = 1'b1;
                    s.frac = 17'sd32768;
                end else begin
                    // truncation toward zero: divide the magnitude
                    s.frac = v[16] ? -$signed(qx) : $signed(qx);
                end
            end
            default: begin
                s.frac = '0;
            end
        endcase
        s.forced = frc && (p.kind == KIND_SUMMARY);
        return s;
    endfunction

    // timestamp << 15 plus the signed fraction, wrapping at 64 bits
    function automatic t_pipe f_time(input t_pipe p);
        t_pipe             s;
        logic [TIME_W-1:0] t;
        s = p;
        t = {1'b0, p.ts, 15'd0} + {{(TIME_W-17){p.frac[16]}}, p.frac};
        s.tval = (p.kind == KIND_SUMMARY) ? t : '0;
        s.quo  = '0;
        s.rem  = '0;
        return s;
    endfunction

    // one 16-bit digit of ((t*8) mod 2^64)/10 = (t[60:0]<<2)/5
    function automatic t_pipe f_digit(input t_pipe p, input int j);
        t_pipe              s;
        logic [TIME_W-1:0]  y;
        logic [18:0]        v;
        logic [38:0]        prod;
        logic [DIGIT_W-1:0] qd;
        logic [18:0]        five_q;
        logic [18:0]        r;
        s      = p;
        y      = {1'b0, p.tval[60:0], 2'b00};
        v      = {p.rem, y[TIME_W-1-DIGIT_W*j -: DIGIT_W]};
        prod   = 39'(v) * 39'(RECIP_DIGIT);
        qd     = prod[RECIP_DIGIT_SH +: DIGIT_W];
        five_q = {1'b0, qd, 2'b00} + {3'b000, qd};
        r      = v - five_q;
        s.rem  = r[2:0];
        s.quo  = {p.quo[TIME_W-DIGIT_W-1:0], qd};
        if ((j == DIGITS - 1) && (p.mode == RATE_250)) begin
            s.tval = {p.quo[TIME_W-DIGIT_W-1:0], qd};
        end
        return s;
    endfunction

    // ---------------------------------------------------------------
    // handshake: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    always_comb begin
        rdy[LMEP_NSTAGE] = o_item.ready;
        for (int k = LMEP_NSTAGE - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign i_word.ready = rdy[0];
    assign in_acc       = i_word.valid && rdy[0];

    // ---------------------------------------------------------------
    // word decode at acceptance
    // ---------------------------------------------------------------
    always_comb begin
        logic [WORD_W-1:0]  w;
        logic [4:0]         start5;
        logic [INDEX_W-1:0] start;
        logic [INDEX_W-1:0] total;
        logic [INDEX_W:0]   pos_inc;
        logic [INDEX_W-1:0] rel;
        logic [INDEX_W-1:0] hl14;

        w       = i_word.stream_word;
        n_pos   = r_pos;
        n_hl    = r_hl;
        n_el    = r_el;
        n_ids   = r_ids;
        n_tlo   = r_tlo;
        n_thi   = r_thi;
        in_emit = 1'b0;
        n_in    = '0;

        hl14    = {9'd0, r_hl};
        start5  = (r_hl > 5'(FIXED_WORDS)) ? r_hl : 5'(FIXED_WORDS);
        start   = {9'd0, start5};
        total   = (r_el > start) ? r_el : start;
        pos_inc = {1'b0, r_pos} + 15'd1;
        rel     = r_pos - FIXED_WORDS;

        n_in.ids  = r_ids;
        n_in.mode = r_mode;

        if (r_pos == POS_HEADER) begin
            n_ids = {w[31], w[11:0]};
            n_hl  = w[16:12];
            n_el  = w[30:17];
        end else if (r_pos == POS_TS_LOW) begin
            n_tlo = w;
        end else if (r_pos == POS_TS_HIGH) begin
            n_thi = w;
        end else if (r_pos == POS_ENERGY) begin
            in_emit      = 1'b1;
            n_in.kind    = KIND_SUMMARY;
            n_in.energy  = w[15:0];
            n_in.samples = w[30:16];
            n_in.oor     = w[31];
            n_in.ts      = {r_thi[15:0], r_tlo};
            n_in.cfd     = r_thi[31:16];
        end else if (r_pos < hl14) begin
            // extended header: energy sums and/or QDC sums
            n_in.value = w;
            if (r_hl == HDR_ESUM) begin
                in_emit    = 1'b1;
                n_in.kind  = KIND_ESUM;
                n_in.index = rel;
            end else if (r_hl == HDR_QDC) begin
                in_emit    = 1'b1;
                n_in.kind  = KIND_QDC;
                n_in.index = rel;
            end else if (r_hl == HDR_BOTH) begin
                in_emit = 1'b1;
                if (rel < ESUM_WORDS) begin
                    n_in.kind  = KIND_ESUM;
                    n_in.index = rel;
                end else begin
                    n_in.kind  = KIND_QDC;
                    n_in.index = rel - ESUM_WORDS;
                end
            end
        end else if (r_trace) begin
            in_emit    = 1'b1;
            n_in.kind  = KIND_TRACE;
            n_in.index = r_pos - start;
            n_in.value = w;
        end

        // header word always moves on; later words wrap at the event end
        if (r_pos == POS_HEADER) begin
            n_pos = POS_TS_LOW;
        end else if (pos_inc >= {1'b0, total}) begin
            n_pos = POS_HEADER;
        end else begin
            n_pos = pos_inc[INDEX_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // time stages
    // ---------------------------------------------------------------
    always_comb begin
        n_st[0] = n_in;
        n_st[1] = f_frac(r_st[0]);
        n_st[2] = f_time(r_st[1]);
        for (int j = 0; j < DIGITS; j++) begin
            n_st[3+j] = f_digit(r_st[2+j], j);
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_HEADER;
            r_hl    <= '0;
            r_el    <= '0;
            r_ids   <= '0;
            r_tlo   <= '0;
            r_thi   <= '0;
            r_mode  <= RATE_100;
            r_trace <= 1'b0;
            r_v     <= '0;
        end else begin
            if (in_acc) begin
                r_pos <= n_pos;
                r_hl  <= n_hl;
                r_el  <= n_el;
                r_ids <= n_ids;
                r_tlo <= n_tlo;
                r_thi <= n_thi;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_RATE:  r_mode  <= t_rate'(i_cfg_data);
                    CFG_TRACE: r_trace <= i_cfg_data[0];
                    default:   r_trace <= r_trace;
                endcase
            end
            if (rdy[0]) begin
                r_v[0] <= in_acc && in_emit;
            end
            for (int k = 1; k < LMEP_NSTAGE; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LMEP_NSTAGE; k++) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // output
    // ---------------------------------------------------------------
    assign o_item.valid         = r_v[LAST];
    assign o_item.item_kind     = r_st[LAST].kind;
    assign o_item.item_index    = r_st[LAST].index;
    assign o_item.item_value    = r_st[LAST].value;
    assign o_item.channel_id    = r_st[LAST].ids[3:0];
    assign o_item.slot_id       = r_st[LAST].ids[7:4];
    assign o_item.crate_id      = r_st[LAST].ids[11:8];
    assign o_item.finish_flag   = r_st[LAST].ids[12];
    assign o_item.event_time    = r_st[LAST].tval;
    assign o_item.cfd_forced    = r_st[LAST].forced;
    assign o_item.event_energy  = r_st[LAST].energy;
    assign o_item.trace_samples = r_st[LAST].samples;
    assign o_item.out_of_range  = r_st[LAST].oor;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_hdr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_pos == POS_HEADER)) |=> (r_pos == POS_TS_LOW))
        else $error("header word did not advance to timestamp word");

    a_no_time_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && (r_st[LAST].kind != KIND_SUMMARY))
            |-> ((r_st[LAST].tval == '0) && !r_st[LAST].forced))
        else $error("non-summary item carries time data");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rdy[0] |-> (&r_v))
        else $error("input stalled while pipeline has a free stage");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> (r_st[LAST].rem <= 3'd4))
        else $error("time divider remainder out of range");

endmodule
